[rtl/lphm_pkg.sv]
`timescale 1ns / 1ps
package lphm_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = 7;
	localparam int KEY_W  = 64;
	localparam int VAL_W  = 64;

	localparam logic [63:0] MIX_C1 = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] MIX_C2 = 64'hC4CEB9FE1A85EC53;
	localparam int MIX_SHIFT = 33;

	localparam logic [CNT_W-1:0] LOAD_LIMIT_RST = 7'd48;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_LOOKUP = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_LIST   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_NULL = 2'd1,
		STAT_FULL = 2'd2
	} stat_t;

	// control between the sequencer and the hash unit
	typedef struct packed {
		logic start;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef struct packed {
		logic done;
		logic [SLOT_W-1:0] slot;
	} hash_rsp_t;

	// slot memory write port
	typedef struct packed {
		logic we;
		logic [SLOT_W-1:0] addr;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} ram_wr_t;

endpackage

[rtl/linear_probe_hash_map.sv]
`timescale 1ns / 1ps
// Flow: the item is accepted, then the hash state runs 8 steps on the shared 32x32
// multiplier plus the done handoff, then each probed slot takes a registered slot
// memory read, then a compare, and then the result loads the output register.
// List walks slots up to the last live entry, with a read and a compare per slot;
// clear, null keys and unknown modes go straight to the output register.
// One item at a time: s_tready is high only while the sequencer is idle.
// Reset (arst_n low, asynchronous) empties every slot, zeroes the live count and
// sets load_limit to 48; slot memory contents stay undefined until written.
module linear_probe_hash_map import lphm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // key[63:0], value[127:64]
	input  logic [2:0]   s_tuser,  // mode[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // out_key[63:0], out_value[127:64], found[128],
	                               // status[130:129], live_count[137:131], zero[143:138]
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_HASH = 7'b0000010,
		S_RD   = 7'b0000100,
		S_CMP  = 7'b0001000,
		S_EMIT = 7'b0010000,
		S_LRD  = 7'b0100000,
		S_LCMP = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] steps_q;
	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] tomb_q;
	logic [SLOT_W-1:0] pos_q;
	logic [SLOT_W-1:0] tpos_q;
	logic tomb_v_q;

	logic [2:0]       mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic [KEY_W-1:0] res_key_q;
	logic [VAL_W-1:0] res_val_q;
	logic             res_found_q;
	stat_t            res_stat_q;

	logic             ovalid_q;
	logic [KEY_W-1:0] okey_q;
	logic [VAL_W-1:0] oval_q;
	logic             ofound_q;
	stat_t            ostat_q;
	logic [CNT_W-1:0] ocount_q;
	logic             olast_q;

	hash_req_t hreq;
	hash_rsp_t hrsp;
	ram_wr_t   wr;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_value;

	logic in_acc;
	logic out_free;
	logic emit;
	logic [KEY_W-1:0] in_key;
	logic [2:0] in_mode;
	logic cur_used;
	logic cur_tomb;
	logic hit;
	logic probe_end;
	logic t_v;
	logic [SLOT_W-1:0] t_pos;
	logic cfg_we;

	assign in_key   = s_tdata[63:0];
	assign in_mode  = s_tuser;
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;
	assign emit     = ((state_q == S_EMIT) || (state_q == S_LCMP && cur_used)) && out_free;

	assign cur_used  = used_q[pos_q];
	assign cur_tomb  = tomb_q[pos_q];
	assign hit       = cur_used && (rd_key == key_q);
	assign probe_end = (steps_q + 7'd1) == CNT_W'(SLOTS);
	assign t_v       = tomb_v_q || cur_tomb;
	assign t_pos     = tomb_v_q ? tpos_q : pos_q;

	assign hreq.start = in_acc && (in_mode == MODE_INSERT || in_mode == MODE_LOOKUP
		|| in_mode == MODE_REMOVE) && (in_key != '0);
	assign hreq.key   = in_key;

	lphm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	// write slot on insert at the end of the probe
	always_comb begin
		wr.we    = 1'b0;
		wr.addr  = pos_q;
		wr.key   = key_q;
		wr.value = val_q;
		if (state_q == S_CMP && mode_q == MODE_INSERT) begin
			if (hit) begin
				wr.we = 1'b1;
			end else if (count_q < limit_q) begin
				if (!cur_used && !cur_tomb) begin
					wr.we   = 1'b1;
					wr.addr = tomb_v_q ? tpos_q : pos_q;
				end else if (probe_end && t_v) begin
					wr.we   = 1'b1;
					wr.addr = t_pos;
				end
			end
		end
	end

	lphm_ram u_ram (
		.clk      (clk),
		.wr       (wr),
		.raddr    (pos_q),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	// configuration register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {25'b0, limit_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LOAD_LIMIT_RST;
		else if (cfg_we) limit_q <= pwdata[CNT_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			used_q   <= '0;
			tomb_q   <= '0;
			tomb_v_q <= 1'b0;
			steps_q  <= '0;
			n_q      <= '0;
			pos_q    <= '0;
			tpos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (hreq.start) begin
							state_q <= S_HASH;
						end else if (in_mode == MODE_LIST && count_q != '0) begin
							pos_q   <= '0;
							n_q     <= '0;
							state_q <= S_LRD;
						end else begin
							if (in_mode == MODE_CLEAR) begin
								used_q  <= '0;
								tomb_q  <= '0;
								count_q <= '0;
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_HASH: begin
					if (hrsp.done) begin
						pos_q    <= hrsp.slot;
						steps_q  <= '0;
						tomb_v_q <= 1'b0;
						state_q  <= S_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (hit) begin
						if (mode_q == MODE_REMOVE) begin
							used_q[pos_q] <= 1'b0;
							tomb_q[pos_q] <= 1'b1;
							count_q <= count_q - 7'd1;
						end
						state_q <= S_EMIT;
					end else if ((!cur_used && !cur_tomb) || probe_end) begin
						if (wr.we) begin
							used_q[wr.addr] <= 1'b1;
							tomb_q[wr.addr] <= 1'b0;
							count_q <= count_q + 7'd1;
						end
						state_q <= S_EMIT;
					end else begin
						if (cur_tomb && !tomb_v_q) begin
							tomb_v_q <= 1'b1;
							tpos_q   <= pos_q;
						end
						steps_q <= steps_q + 7'd1;
						pos_q   <= pos_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q  <= S_IDLE;
					end
				end
				S_LRD: state_q <= S_LCMP;
				S_LCMP: begin
					if (!cur_used) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_LRD;
					end else if (out_free) begin
						n_q      <= n_q + 7'd1;
						if ((n_q + 7'd1) == count_q) begin
							state_q <= S_IDLE;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= S_LRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// raise valid on a new result, drop it after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (emit) ovalid_q <= 1'b1;
		else if (m_tready) ovalid_q <= 1'b0;
	end

	// latch the item and form the single result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q      <= in_mode;
			key_q       <= in_key;
			val_q       <= s_tdata[127:64];
			res_key_q   <= in_key;
			res_val_q   <= '0;
			res_found_q <= 1'b0;
			res_stat_q  <= STAT_DONE;
			if (hreq.start == 1'b0 && in_key == '0 && (in_mode == MODE_INSERT
				|| in_mode == MODE_LOOKUP || in_mode == MODE_REMOVE)) begin
				res_stat_q <= STAT_NULL;
			end
		end else if (state_q == S_CMP) begin
			if (hit) begin
				res_found_q <= 1'b1;
				if (mode_q == MODE_LOOKUP) res_val_q <= rd_value;
			end else if (((!cur_used && !cur_tomb) || probe_end)
				&& mode_q == MODE_INSERT && !wr.we) begin
				res_stat_q <= STAT_FULL;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			okey_q   <= res_key_q;
			oval_q   <= res_val_q;
			ofound_q <= res_found_q;
			ostat_q  <= res_stat_q;
			ocount_q <= count_q;
			olast_q  <= 1'b1;
		end else if (state_q == S_LCMP && cur_used && out_free) begin
			okey_q   <= rd_key;
			oval_q   <= rd_value;
			ofound_q <= 1'b1;
			ostat_q  <= STAT_DONE;
			ocount_q <= count_q;
			olast_q  <= (n_q + 7'd1) == count_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'b0, ocount_q, ostat_q, ofound_q, oval_q, okey_q};
	assign m_tlast  = olast_q;

	// live count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("live count exceeds slot count");

	// slot memory written only at the end of an insert probe
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == S_CMP && mode_q == MODE_INSERT))
		else $error("slot write outside insert compare");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("item accepted while busy");

	// count moves only on probe end or clear
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_CMP
		|| $past(state_q) == S_IDLE))
		else $error("live count changed outside update points");

endmodule

[rtl/lphm_hash.sv]
`timescale 1ns / 1ps
module lphm_hash import lphm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hash_req_t req,
	output hash_rsp_t rsp
);

	logic        busy_q;
	logic        ph_q;
	logic [1:0]  st_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic        done_q;
	logic [SLOT_W-1:0] slot_q;

	logic [63:0] b;
	logic [31:0] opa;
	logic [31:0] opb;
	logic [31:0] hi_sum;
	logic [63:0] acc_n;
	logic [63:0] mix;

	// select one 32x32 partial product per cycle
	always_comb begin
		b = ph_q ? MIX_C2 : MIX_C1;
		case (st_q)
			2'd1: begin
				opa = a_q[31:0];
				opb = b[63:32];
			end
			2'd2: begin
				opa = a_q[63:32];
				opb = b[31:0];
			end
			default: begin
				opa = a_q[31:0];
				opb = b[31:0];
			end
		endcase
		hi_sum = acc_q[63:32] + prod_q[31:0];
		acc_n  = {hi_sum, acc_q[31:0]};
		mix    = acc_n ^ (acc_n >> MIX_SHIFT);
	end

	// registered shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= {32'b0, opa} * {32'b0, opb};
	end

	// step the two multiplications
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			st_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				st_q   <= 2'd0;
			end else if (busy_q) begin
				st_q <= st_q + 2'd1;
				if (st_q == 2'd3) begin
					if (ph_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					ph_q <= ~ph_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.key ^ (req.key >> MIX_SHIFT);
		end else if (busy_q) begin
			case (st_q)
				2'd1: acc_q <= prod_q;
				2'd2: acc_q <= acc_n;
				2'd3: begin
					if (ph_q) slot_q <= mix[SLOT_W-1:0];
					else a_q <= mix;
				end
				default: ;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.slot = slot_q;

endmodule

[rtl/lphm_ram.sv]
`timescale 1ns / 1ps
module lphm_ram import lphm_pkg::*; (
	input  logic              clk,
	input  ram_wr_t           wr,
	input  logic [SLOT_W-1:0] raddr,
	output logic [KEY_W-1:0]  rd_key,
	output logic [VAL_W-1:0]  rd_value
);

	logic [KEY_W+VAL_W-1:0] mem [SLOTS];
	logic [KEY_W+VAL_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.addr] <= {wr.key, wr.value};
		rd_q <= mem[raddr];
	end

	assign rd_key   = rd_q[KEY_W+VAL_W-1:VAL_W];
	assign rd_value = rd_q[VAL_W-1:0];

endmodule
